[hw/rtl/hms_pkg.sv]
// Package for the hours/minutes/seconds up/down stopwatch.
// Holds the event codes, count limits, result type and the digit split helper.
// No dependencies; every other file of the block uses it.
`default_nettype none

package hms_pkg;

  // Count widths and limits.
  localparam int SEC_W    = 6;
  localparam int MIN_W    = 6;
  localparam int HOUR_W   = 5;
  localparam int OP_W     = 4;
  localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;
  localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
  localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;

  // Event codes carried by the opcode field.
  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 4'd0,
    OP_CLEAR    = 4'd1,
    OP_PAUSE    = 4'd2,
    OP_RESUME   = 4'd3,
    OP_SET_DIR  = 4'd4,
    OP_HOUR_UP  = 4'd5,
    OP_HOUR_DN  = 4'd6,
    OP_MIN_UP   = 4'd7,
    OP_MIN_DN   = 4'd8,
    OP_SEC_UP   = 4'd9,
    OP_SEC_DN   = 4'd10
  } op_t;

  // Tens and ones digit of a value below 64.
  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } dec2_t;

  // One result item.
  typedef struct packed {
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [3:0] min_ones;
    logic [2:0] min_tens;
    logic [3:0] hour_ones;
    logic [1:0] hour_tens;
    logic       running_flag;
    logic       down_flag;
    logic       buzzer;
  } res_t;

  // Splits a count (at most 63) into two decimal digits with a compare chain.
  function automatic dec2_t split_dec(input logic [5:0] v);
    dec2_t      d;
    logic [5:0] base;
    begin
      if (v >= 6'd60) begin
        d.tens = 3'd6;
        base   = 6'd60;
      end else if (v >= 6'd50) begin
        d.tens = 3'd5;
        base   = 6'd50;
      end else if (v >= 6'd40) begin
        d.tens = 3'd4;
        base   = 6'd40;
      end else if (v >= 6'd30) begin
        d.tens = 3'd3;
        base   = 6'd30;
      end else if (v >= 6'd20) begin
        d.tens = 3'd2;
        base   = 6'd20;
      end else if (v >= 6'd10) begin
        d.tens = 3'd1;
        base   = 6'd10;
      end else begin
        d.tens = 3'd0;
        base   = 6'd0;
      end
      d.ones = 4'(v - base);
      return d;
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/hms_if.sv]
// Channel interfaces of the stopwatch: event input and display result output.
// Depends on hms_pkg for the opcode width.
`default_nettype none

interface hms_in_if;
  logic                    valid;
  logic                    ready;
  logic [hms_pkg::OP_W-1:0] opcode;
  logic                    down_mode;

  modport source (output valid, output opcode, output down_mode, input ready);
  modport sink   (input valid, input opcode, input down_mode, output ready);
endinterface

interface hms_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] sec_ones;
  logic [2:0] sec_tens;
  logic [3:0] min_ones;
  logic [2:0] min_tens;
  logic [3:0] hour_ones;
  logic [1:0] hour_tens;
  logic       running_flag;
  logic       down_flag;
  logic       buzzer;

  modport source (
    output valid, output sec_ones, output sec_tens, output min_ones, output min_tens,
    output hour_ones, output hour_tens, output running_flag, output down_flag,
    output buzzer, input ready
  );
  modport sink (
    input valid, input sec_ones, input sec_tens, input min_ones, input min_tens,
    input hour_ones, input hour_tens, input running_flag, input down_flag,
    input buzzer, output ready
  );
endinterface

`default_nettype wire

[hw/rtl/hms_up_down_stopwatch_top.sv]
// Top level of the hours/minutes/seconds up/down stopwatch.
// Depends on hms_pkg, hms_if, hms_core and hms_obuf.
//
// Every event item (tick, clear, pause, resume, direction, or raise/lower of a
// field) produces exactly one result item with the six time digits, the run
// and direction flags and the buzzer. One item is taken per clock cycle while
// in_if.ready is high; when the output buffer is empty its result is valid on
// the cycle after acceptance, otherwise it waits behind the older result. The
// time registers update on acceptance, and a two-entry output buffer lets input
// continue while a result waits, so in_if.ready drops only when both are full.
`default_nettype none

module hms_up_down_stopwatch_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hms_in_if.sink     in_if,
  hms_out_if.source  out_if
);
  import hms_pkg::*;

  logic fire;
  logic buf_ready;
  res_t res_nxt;
  res_t out_res;

  assign in_if.ready = buf_ready;
  assign fire        = in_if.valid && buf_ready;

  hms_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .opcode    (in_if.opcode),
    .down_mode (in_if.down_mode),
    .res_nxt   (res_nxt)
  );

  hms_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_data  (res_nxt),
    .push_ready (buf_ready),
    .pop_valid  (out_if.valid),
    .pop_ready  (out_if.ready),
    .pop_data   (out_res)
  );

  // Unpack the result item onto the output channel.
  assign out_if.sec_ones     = out_res.sec_ones;
  assign out_if.sec_tens     = out_res.sec_tens;
  assign out_if.min_ones     = out_res.min_ones;
  assign out_if.min_tens     = out_res.min_tens;
  assign out_if.hour_ones    = out_res.hour_ones;
  assign out_if.hour_tens    = out_res.hour_tens;
  assign out_if.running_flag = out_res.running_flag;
  assign out_if.down_flag    = out_res.down_flag;
  assign out_if.buzzer       = out_res.buzzer;

endmodule

`default_nettype wire

[hw/rtl/hms_core.sv]
// Time and mode registers of the stopwatch with the per-event update logic.
// Depends on hms_pkg; produces the result item that follows each event.
`default_nettype none

module hms_core (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     fire,
  input  wire logic [hms_pkg::OP_W-1:0] opcode,
  input  wire logic                     down_mode,
  output hms_pkg::res_t                 res_nxt
);
  import hms_pkg::*;

  logic [SEC_W-1:0]  sec_r,  sec_nxt;
  logic [MIN_W-1:0]  min_r,  min_nxt;
  logic [HOUR_W-1:0] hour_r, hour_nxt;
  logic              run_r,  run_nxt;
  logic              down_r, down_nxt;

  logic [HOUR_W-1:0] hour_inc;
  logic              sec_wrap;
  logic              min_wrap;
  dec2_t             sec_d, min_d, hour_d;

  assign hour_inc = (hour_r >= HOUR_MAX) ? '0 : hour_r + 1'b1;
  assign sec_wrap = (sec_r >= SEC_MAX);
  assign min_wrap = (min_r >= MIN_MAX);

  // Next state for the event; the carry and borrow chains run from seconds through minutes to hours.
  always_comb begin
    logic do_sec_inc;
    logic do_sec_dec;
    logic do_min_inc;
    logic do_min_dec;
    do_sec_inc = 1'b0;
    do_sec_dec = 1'b0;
    do_min_inc = 1'b0;
    do_min_dec = 1'b0;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hour_nxt   = hour_r;
    run_nxt    = run_r;
    down_nxt   = down_r;

    case (op_t'(opcode))
      OP_TICK: begin
        if (run_r) begin
          do_sec_dec = down_r;
          do_sec_inc = !down_r;
        end
      end
      OP_CLEAR: begin
        sec_nxt  = '0;
        min_nxt  = '0;
        hour_nxt = '0;
      end
      OP_PAUSE:   run_nxt  = 1'b0;
      OP_RESUME:  run_nxt  = 1'b1;
      OP_SET_DIR: down_nxt = down_mode;
      OP_HOUR_UP: hour_nxt = hour_inc;
      OP_HOUR_DN: begin
        if (hour_r != '0) hour_nxt = hour_r - 1'b1;
      end
      OP_MIN_UP:  do_min_inc = 1'b1;
      OP_MIN_DN:  do_min_dec = 1'b1;
      OP_SEC_UP:  do_sec_inc = 1'b1;
      OP_SEC_DN:  do_sec_dec = 1'b1;
      default: ;
    endcase

    // Counting up: a second wrap carries into the minutes.
    if (do_sec_inc) begin
      if (sec_wrap) begin
        sec_nxt    = '0;
        do_min_inc = 1'b1;
      end else begin
        sec_nxt = sec_r + 1'b1;
      end
    end
    if (do_min_inc) begin
      if (min_wrap) begin
        min_nxt  = '0;
        hour_nxt = hour_inc;
      end else begin
        min_nxt = min_r + 1'b1;
      end
    end

    // Counting down: borrow from the next higher nonzero field, and hold at zero.
    if (do_sec_dec) begin
      if (sec_r != '0) begin
        sec_nxt = sec_r - 1'b1;
      end else if (min_r != '0) begin
        min_nxt = min_r - 1'b1;
        sec_nxt = SEC_MAX;
      end else if (hour_r != '0) begin
        hour_nxt = hour_r - 1'b1;
        min_nxt  = MIN_MAX;
        sec_nxt  = SEC_MAX;
      end
    end
    if (do_min_dec) begin
      if (min_r != '0) begin
        min_nxt = min_r - 1'b1;
      end else if (hour_r != '0) begin
        hour_nxt = hour_r - 1'b1;
        min_nxt  = MIN_MAX;
      end
    end
  end

  // State registers advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= '0;
      run_r  <= 1'b1;
      down_r <= 1'b0;
    end else if (fire) begin
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      run_r  <= run_nxt;
      down_r <= down_nxt;
    end
  end

  // Result item built from the updated state.
  assign sec_d  = split_dec(sec_nxt);
  assign min_d  = split_dec(min_nxt);
  assign hour_d = split_dec({1'b0, hour_nxt});

  always_comb begin
    res_nxt.sec_ones     = sec_d.ones;
    res_nxt.sec_tens     = sec_d.tens;
    res_nxt.min_ones     = min_d.ones;
    res_nxt.min_tens     = min_d.tens;
    res_nxt.hour_ones    = hour_d.ones;
    res_nxt.hour_tens    = hour_d.tens[1:0];
    res_nxt.running_flag = run_nxt;
    res_nxt.down_flag    = down_nxt;
    res_nxt.buzzer       = down_nxt && (sec_nxt == '0) && (min_nxt == '0) && (hour_nxt == '0);
  end

endmodule

`default_nettype wire

[hw/rtl/hms_obuf.sv]
// Two-entry result buffer (output register plus skid register) of the stopwatch.
// Depends on hms_pkg for the result type.
`default_nettype none

module hms_obuf (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire hms_pkg::res_t push_data,
  output logic        push_ready,
  output logic        pop_valid,
  input  wire logic   pop_ready,
  output hms_pkg::res_t pop_data
);
  import hms_pkg::*;

  res_t main_r;
  res_t skid_r;
  logic main_v_r;
  logic skid_v_r;
  logic pop;

  assign pop        = main_v_r && pop_ready;
  assign push_ready = !skid_v_r;
  assign pop_valid  = main_v_r;
  assign pop_data   = main_r;

  // Valid flags: the skid entry fills only when the main entry is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) skid_v_r <= 1'b0;
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) main_r <= skid_r;
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the hours/minutes/seconds up/down stopwatch top level.
// Depends on hms_pkg, the hms_in_if and hms_out_if channel interfaces and the RTL below them.
// A scoreboard class predicts each display item and compares it field by field.

module tb_top;
  import hms_pkg::*;

  localparam int N_ITEMS    = 1350;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_AT    = 120;
  localparam int HOLD_LEN   = 90;
  localparam int TAIL       = 8;

  // Opcodes that the block does not decode.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd11;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            down_mode;
  } event_t;

  // Tracks the stopwatch time and flags, and holds the display items still owed.
  class hms_time_board;
    logic [SEC_W-1:0]  secs;
    logic [MIN_W-1:0]  mins;
    logic [HOUR_W-1:0] hrs;
    logic              run_on;
    logic              count_dn;
    res_t              owed_q[$];
    int                n_bad;

    function new();
      secs     = '0;
      mins     = '0;
      hrs      = '0;
      run_on   = 1'b1;
      count_dn = 1'b0;
      n_bad    = 0;
    endfunction

    function void hour_up();
      hrs = (hrs >= HOUR_MAX) ? '0 : hrs + 1'b1;
    endfunction

    function void min_up();
      if (mins >= MIN_MAX) begin
        mins = '0;
        hour_up();
      end else begin
        mins = mins + 1'b1;
      end
    endfunction

    function void sec_up();
      if (secs >= SEC_MAX) begin
        secs = '0;
        min_up();
      end else begin
        secs = secs + 1'b1;
      end
    endfunction

    // Borrows stop at 00:00:00.
    function void min_down();
      if (mins != 0) begin
        mins = mins - 1'b1;
      end else if (hrs != 0) begin
        hrs  = hrs - 1'b1;
        mins = MIN_MAX;
      end
    endfunction

    function void sec_down();
      if (secs != 0) begin
        secs = secs - 1'b1;
      end else if (mins != 0) begin
        mins = mins - 1'b1;
        secs = SEC_MAX;
      end else if (hrs != 0) begin
        hrs  = hrs - 1'b1;
        mins = MIN_MAX;
        secs = SEC_MAX;
      end
    endfunction

    // Applies one accepted event and queues the display item it must produce.
    function void note_event(event_t ev);
      res_t r;
      case (ev.opcode)
        OP_TICK: begin
          if (run_on) begin
            if (count_dn) sec_down();
            else sec_up();
          end
        end
        OP_CLEAR: begin
          secs = '0;
          mins = '0;
          hrs  = '0;
        end
        OP_PAUSE:   run_on = 1'b0;
        OP_RESUME:  run_on = 1'b1;
        OP_SET_DIR: count_dn = ev.down_mode;
        OP_HOUR_UP: hour_up();
        OP_HOUR_DN: if (hrs != 0) hrs = hrs - 1'b1;
        OP_MIN_UP:  min_up();
        OP_MIN_DN:  min_down();
        OP_SEC_UP:  sec_up();
        OP_SEC_DN:  sec_down();
        default: ;
      endcase
      r.sec_ones     = 4'(secs % 10);
      r.sec_tens     = 3'(secs / 10);
      r.min_ones     = 4'(mins % 10);
      r.min_tens     = 3'(mins / 10);
      r.hour_ones    = 4'(hrs % 10);
      r.hour_tens    = 2'(hrs / 10);
      r.running_flag = run_on;
      r.down_flag    = count_dn;
      r.buzzer       = count_dn && secs == 0 && mins == 0 && hrs == 0;
      owed_q.push_back(r);
    endfunction

    function string show(res_t r);
      return $sformatf("%0d%0d:%0d%0d:%0d%0d run=%0b down=%0b buzz=%0b",
                       r.hour_tens, r.hour_ones, r.min_tens, r.min_ones,
                       r.sec_tens, r.sec_ones, r.running_flag, r.down_flag, r.buzzer);
    endfunction

    // Compares one display item with the oldest owed one.
    function void check_result(res_t got);
      res_t  want;
      string bad;
      bad = "";
      if (owed_q.size() == 0) begin
        if (n_bad < 10) $display("unexpected display item: %s", show(got));
        n_bad++;
        return;
      end
      want = owed_q.pop_front();
      if (got.sec_ones !== want.sec_ones) bad = {bad, " sec_ones"};
      if (got.sec_tens !== want.sec_tens) bad = {bad, " sec_tens"};
      if (got.min_ones !== want.min_ones) bad = {bad, " min_ones"};
      if (got.min_tens !== want.min_tens) bad = {bad, " min_tens"};
      if (got.hour_ones !== want.hour_ones) bad = {bad, " hour_ones"};
      if (got.hour_tens !== want.hour_tens) bad = {bad, " hour_tens"};
      if (got.running_flag !== want.running_flag) bad = {bad, " running_flag"};
      if (got.down_flag !== want.down_flag) bad = {bad, " down_flag"};
      if (got.buzzer !== want.buzzer) bad = {bad, " buzzer"};
      if (bad != "") begin
        if (n_bad < 10) begin
          $display("display mismatch at %0t on%s", $realtime, bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
        n_bad++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hms_in_if  in_ch ();
  hms_out_if out_ch ();

  hms_up_down_stopwatch_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  hms_time_board board;
  event_t        stim_q[$];
  int            phase;
  bit            hold_req;
  bit            driver_done;

  // Clock and the single reset pulse.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic add(logic [OP_W-1:0] op, logic dm);
    event_t ev;
    ev.opcode    = op;
    ev.down_mode = dm;
    stim_q.push_back(ev);
  endtask

  task automatic add_rnd(logic [OP_W-1:0] op);
    add(op, rand_bit());
  endtask

  // Corners: holds at zero, paused ticks, borrows and carries, spare opcodes.
  task automatic build_directed();
    add(OP_TICK, 1'b0);
    add(OP_SEC_DN, 1'b1);
    add(OP_SEC_DN, 1'b0);
    add(OP_MIN_DN, 1'b1);
    add(OP_HOUR_DN, 1'b0);
    add(OP_SET_DIR, 1'b1);
    add(OP_TICK, 1'b0);
    add(OP_SEC_UP, 1'b1);
    add(OP_MIN_DN, 1'b0);
    add(OP_PAUSE, 1'b1);
    add(OP_TICK, 1'b1);
    add(OP_RESUME, 1'b0);
    add(OP_TICK, 1'b1);
    add(OP_HOUR_UP, 1'b0);
    add(OP_TICK, 1'b0);
    add(OP_SET_DIR, 1'b0);
    add(OP_SEC_UP, 1'b1);
    add(OP_MIN_DN, 1'b1);
    add(OP_MIN_UP, 1'b0);
    add(OP_SPARE_LO, 1'b1);
    add(OP_SPARE_HI, 1'b0);
    add(OP_CLEAR, 1'b1);
  endtask

  // Random part: purposeful sequences, runs of one event, and some noise.
  task automatic build_random();
    int pick;
    int k;
    logic [OP_W-1:0] op;
    while (stim_q.size() < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // Walk to 23:59:59, then step across the wrap in either direction.
        add_rnd(OP_CLEAR);
        repeat (23) add_rnd(OP_HOUR_UP);
        add_rnd(OP_MIN_DN);
        add_rnd(OP_HOUR_UP);
        add_rnd(OP_SEC_DN);
        add_rnd(OP_MIN_UP);
        add_rnd(OP_RESUME);
        add(OP_SET_DIR, rand_bit());
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 4))
            0: op = OP_TICK;
            1: op = OP_SEC_UP;
            2: op = OP_MIN_UP;
            3: op = OP_HOUR_UP;
            default: op = OP_SEC_DN;
          endcase
          add_rnd(op);
        end
      end else if (pick < 35) begin
        // Short countdown; without the optional minute or hour it runs into zero and sits there.
        add_rnd(OP_CLEAR);
        add(OP_SET_DIR, 1'b1);
        k = $urandom_range(0, 3);
        repeat (k) add_rnd(OP_SEC_UP);
        case ($urandom_range(0, 2))
          0: add_rnd(OP_MIN_UP);
          1: add_rnd(OP_HOUR_UP);
          default: ;
        endcase
        add_rnd(OP_RESUME);
        repeat (k + $urandom_range(1, 4)) add_rnd(OP_TICK);
      end else if (pick < 75) begin
        // A run of one event.
        op = 4'($urandom_range(0, 10));
        repeat ($urandom_range(1, 30)) add_rnd(op);
      end else begin
        repeat ($urandom_range(1, 8)) add_rnd(4'($urandom_range(0, 15)));
      end
    end
  endtask

  // Event sender.
  initial begin
    int  sent;
    int  drain_at;
    bit  hold_fired;
    int  idle_pct;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= '0;
    in_ch.down_mode <= 1'b0;
    board       = new();
    phase       = 0;
    hold_req    = 1'b0;
    driver_done = 1'b0;
    hold_fired  = 1'b0;
    sent        = 0;
    build_directed();
    build_random();
    drain_at = stim_q.size() * 5 / 8;
    // Wait until reset has been seen released at a clock edge.
    while (rst_n !== 1'b1) @(posedge clk);
    while (sent < stim_q.size()) begin
      @(posedge clk);
      if (in_ch.valid && in_ch.ready) begin
        board.note_event(stim_q[sent]);
        sent++;
      end
      phase = (sent * 4) / stim_q.size();
      if (phase > 3) phase = 3;
      if (sent == HOLD_AT && !hold_fired) begin
        hold_fired = 1'b1;
        hold_req   = 1'b1;
      end
      idle_pct = (phase == 1) ? 81 : (phase == 3) ? 38 : 0;
      // An offered item stays until it is taken.
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (sent < stim_q.size() && !(sent == drain_at && board.pending() != 0) &&
            !roll(idle_pct)) begin
          in_ch.valid     <= 1'b1;
          in_ch.opcode    <= stim_q[sent].opcode;
          in_ch.down_mode <= stim_q[sent].down_mode;
        end else begin
          in_ch.valid     <= 1'b0;
          in_ch.opcode    <= 4'($urandom_range(0, 15));
          in_ch.down_mode <= rand_bit();
        end
      end
    end
    driver_done = 1'b1;
  end

  // Display receiver with random stalls and one long hold-off.
  initial begin
    res_t got;
    int   hold_left;
    int   stall_pct;
    out_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.sec_ones     = out_ch.sec_ones;
        got.sec_tens     = out_ch.sec_tens;
        got.min_ones     = out_ch.min_ones;
        got.min_tens     = out_ch.min_tens;
        got.hour_ones    = out_ch.hour_ones;
        got.hour_tens    = out_ch.hour_tens;
        got.running_flag = out_ch.running_flag;
        got.down_flag    = out_ch.down_flag;
        got.buzzer       = out_ch.buzzer;
        board.check_result(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      stall_pct = (phase == 2) ? 81 : (phase == 3) ? 38 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !roll(stall_pct);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // End of run: drain owed items, let stray outputs show up, then judge.
  initial begin
    @(posedge clk);
    while (!driver_done) @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (board.n_bad == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/hms_pkg.sv
hw/rtl/hms_if.sv
hw/rtl/hms_core.sv
hw/rtl/hms_obuf.sv
hw/rtl/hms_up_down_stopwatch_top.sv
verif/tb_top.sv
